// ===== hw/rtl/alte_pkg.sv =====
package alte_pkg;

    localparam int CAPACITY   = 256;
    localparam int ELEM_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = 9;
    localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_ERASE  = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_VISIT  = 3'd4,
        CMD_CLEAR  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_INS_PUT,
        S_REM,
        S_ERA_KEY,
        S_ERA,
        S_FLUSH,
        S_SRCH,
        S_VIS
    } t_state;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [ELEM_WIDTH-1:0] wdata;
        logic [ADDR_W-1:0]     raddr;
    } t_mem_req;

    typedef struct packed {
        t_status               status;
        logic [ADDR_W-1:0]     pos;
        logic [ELEM_WIDTH-1:0] rd;
        logic [CNT_W-1:0]      len;
    } t_result;

endpackage

// ===== hw/rtl/array_list_table_engine_top.sv =====
// Channel  Direction  Handshake           Payload
// input    in         i_valid / o_stall   i_command, i_index, i_value
// output   out        o_valid / i_stall   o_status, o_position, o_read_value, o_length
//
// Clear, append, removal of the last entry, spare codes and failed commands finish in the
// idle state, a visit in range once its entry is read. Insert moves entries up from the
// index, other removes move later ones down, erase keys on the entry at the index and
// compacts, search scans from entry 0; the single read port walks one entry a cycle.
// One item is in work at a time; the next transfer is taken once the result has left the
// engine for the output register. Reset is synchronous, active low, and empties the list.
module array_list_table_engine_top
    import alte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [8:0]  i_index,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_position,
    output logic [31:0] o_read_value,
    output logic [8:0]  o_length
);

    t_mem_req              mem_req;
    logic [ELEM_WIDTH-1:0] mem_rdata;
    logic                  res_valid;
    t_result               res;
    logic                  take;
    logic                  r_valid;
    t_result               r_res;

    assign take = res_valid && (!r_valid || !i_stall);

    alte_store u_store (
        .i_clk   (i_clk),
        .i_mem   (mem_req),
        .o_rdata (mem_rdata)
    );

    alte_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_command   (i_command),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_stall     (o_stall),
        .i_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_mem       (mem_req),
        .i_rdata     (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
        if (take) begin
            r_res <= res;
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_res.status;
    assign o_position   = 8'(r_res.pos);
    assign o_read_value = 32'(r_res.rd);
    assign o_length     = 9'(r_res.len);

endmodule

// ===== hw/rtl/alte_store.sv =====
module alte_store
    import alte_pkg::*;
(
    input  logic                  i_clk,
    input  t_mem_req              i_mem,
    output logic [ELEM_WIDTH-1:0] o_rdata
);

    logic [ELEM_WIDTH-1:0] r_mem [CAPACITY];
    logic [ELEM_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_mem[i_mem.waddr] <= i_mem.wdata;
        end
        r_rdata <= r_mem[i_mem.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/alte_seq.sv =====
module alte_seq
    import alte_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [2:0]            i_command,
    input  logic [IDX_W-1:0]      i_index,
    input  logic [31:0]           i_value,
    output logic                  o_stall,
    input  logic                  i_take,
    output logic                  o_res_valid,
    output t_result               o_res,
    output t_mem_req              o_mem,
    input  logic [ELEM_WIDTH-1:0] i_rdata
);

    t_state                r_state, n_state;
    t_cmd                  r_op, n_op;
    logic                  r_done, n_done;
    logic                  r_pend, n_pend;
    logic                  r_last, n_last;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [ADDR_W-1:0]     r_ptr, n_ptr;
    logic [CNT_W-1:0]      r_wptr, n_wptr;
    logic [ADDR_W-1:0]     r_idx, n_idx;
    logic [ELEM_WIDTH-1:0] r_val, n_val;
    logic [ELEM_WIDTH-1:0] r_key, n_key;
    t_status               r_status, n_status;
    logic [ADDR_W-1:0]     r_pos, n_pos;
    logic [ELEM_WIDTH-1:0] r_rd, n_rd;

    logic                  pw;
    logic [CMP_W-1:0]      idx_c;
    logic [CMP_W-1:0]      cnt_c;
    logic [CNT_W-1:0]      cnt_m1;

    assign idx_c  = CMP_W'(i_index);
    assign cnt_c  = CMP_W'(r_count);
    assign cnt_m1 = r_count - CNT_W'(1);

    assign pw = r_pend && (r_op != CMD_SEARCH) &&
                ((r_op != CMD_ERASE) || (i_rdata != r_key));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_pend  <= n_pend;
            r_count <= n_count;
        end
        r_op     <= n_op;
        r_last   <= n_last;
        r_ptr    <= n_ptr;
        r_wptr   <= n_wptr;
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_key    <= n_key;
        r_status <= n_status;
        r_pos    <= n_pos;
        r_rd     <= n_rd;
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_done   = r_done && !i_take;
        n_pend   = 1'b0;
        n_last   = r_last;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_wptr   = r_wptr;
        n_idx    = r_idx;
        n_val    = r_val;
        n_key    = r_key;
        n_status = r_status;
        n_pos    = r_pos;
        n_rd     = r_rd;

        o_mem.we    = pw;
        o_mem.waddr = ADDR_W'(r_wptr);
        o_mem.wdata = i_rdata;
        o_mem.raddr = r_ptr;

        if (pw && (r_op == CMD_ERASE)) begin
            n_wptr = r_wptr + CNT_W'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                o_mem.raddr = ADDR_W'(i_index);
                if (i_valid && !r_done) begin
                    n_op     = t_cmd'(i_command);
                    n_idx    = ADDR_W'(i_index);
                    n_val    = i_value[ELEM_WIDTH-1:0];
                    n_status = ST_OK;
                    n_pos    = '0;
                    n_rd     = '0;
                    n_last   = 1'b0;
                    n_done   = 1'b1;
                    unique case (i_command)
                        CMD_INSERT: begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else if (idx_c > cnt_c) begin
                                n_status = ST_RANGE;
                            end else if (idx_c == cnt_c) begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = ADDR_W'(i_index);
                                o_mem.wdata = i_value[ELEM_WIDTH-1:0];
                                n_count     = r_count + CNT_W'(1);
                            end else begin
                                n_ptr   = ADDR_W'(cnt_m1);
                                n_done  = 1'b0;
                                n_state = S_INS;
                            end
                        end
                        CMD_REMOVE: begin
                            if (idx_c >= cnt_c) begin
                                n_status = ST_RANGE;
                            end else if (idx_c == CMP_W'(cnt_m1)) begin
                                n_count = cnt_m1;
                            end else begin
                                n_ptr   = ADDR_W'(i_index) + ADDR_W'(1);
                                n_done  = 1'b0;
                                n_state = S_REM;
                            end
                        end
                        CMD_ERASE: begin
                            if (idx_c >= cnt_c) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_ERA_KEY;
                            end
                        end
                        CMD_SEARCH: begin
                            if (r_count == '0) begin
                                n_status = ST_MISS;
                            end else begin
                                n_ptr   = '0;
                                n_done  = 1'b0;
                                n_state = S_SRCH;
                            end
                        end
                        CMD_VISIT: begin
                            if (idx_c >= cnt_c) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_VIS;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS: begin
                n_pend = 1'b1;
                n_wptr = CNT_W'(r_ptr) + CNT_W'(1);
                if (r_ptr == r_idx) begin
                    n_state = S_INS_PUT;
                end else begin
                    n_ptr = r_ptr - ADDR_W'(1);
                end
            end
            S_INS_PUT: begin
                if (!r_pend) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_idx;
                    o_mem.wdata = r_val;
                    n_count     = r_count + CNT_W'(1);
                    n_done      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_REM: begin
                n_pend = 1'b1;
                n_wptr = CNT_W'(r_ptr) - CNT_W'(1);
                if (CNT_W'(r_ptr) == cnt_m1) begin
                    n_state = S_FLUSH;
                end else begin
                    n_ptr = r_ptr + ADDR_W'(1);
                end
            end
            S_ERA_KEY: begin
                n_key   = i_rdata;
                n_ptr   = '0;
                n_wptr  = '0;
                n_state = S_ERA;
            end
            S_ERA: begin
                n_pend = 1'b1;
                if (CNT_W'(r_ptr) == cnt_m1) begin
                    n_state = S_FLUSH;
                end else begin
                    n_ptr = r_ptr + ADDR_W'(1);
                end
            end
            S_FLUSH: begin
                if (r_op == CMD_ERASE) begin
                    n_count = pw ? (r_wptr + CNT_W'(1)) : r_wptr;
                end else begin
                    n_count = cnt_m1;
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_SRCH: begin
                if (r_pend && (i_rdata == r_val)) begin
                    n_status = ST_OK;
                    n_pos    = ADDR_W'(r_wptr);
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_last) begin
                    n_status = ST_MISS;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_pend = 1'b1;
                    n_wptr = CNT_W'(r_ptr);
                    n_last = (CNT_W'(r_ptr) == cnt_m1);
                    n_ptr  = r_ptr + ADDR_W'(1);
                end
            end
            S_VIS: begin
                n_rd    = i_rdata;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall     = (r_state != S_IDLE) || r_done;
    assign o_res_valid = r_done;
    assign o_res       = '{status: r_status, pos: r_pos, rd: r_rd, len: r_count};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result pending while walking the store");

    a_ins_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (r_ptr >= r_idx))
        else $error("insert shift passed the target index");

    a_era_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERA) |-> (r_wptr <= CNT_W'(r_ptr)))
        else $error("erase compaction overtook the read pointer");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem.we && (r_state == S_IDLE)) |=> (r_done && (r_status == ST_OK)))
        else $error("store written by a failed command");
`endif

endmodule
